// ----- rtl/core/lcgr_pkg.sv -----
// ----------------------------------------------------------------------------
// lcgr_pkg
// Shared widths, constants, sequencer states and control bundle for the
// minimal standard uniform range generator.
// ----------------------------------------------------------------------------
package lcgr_pkg;

    localparam int SEED_W = 31;
    localparam int DATA_W = 32;
    localparam int SPAN_W = 33;
    localparam int PROD_W = 63;

    // Generator multiplier and prime modulus 2^31 - 1
    localparam logic [DATA_W-1:0] LCG_MUL   = 32'd16807;
    localparam logic [SEED_W-1:0] LCG_MOD   = 31'h7FFF_FFFF;
    localparam logic [SEED_W-1:0] SEED_INIT = 31'd1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_SEED,
        S_FOLD_SEED,
        S_MUL_SPAN,
        S_DIV_SUM,
        S_DIV_QUOT,
        S_OUT_LOAD
    } t_state;

    // One-hot step strobes from the sequencer to the datapath
    typedef struct packed {
        logic idle;
        logic mul_seed;
        logic fold_seed;
        logic mul_span;
        logic div_sum;
        logic div_quot;
        logic out_load;
    } t_ctrl;

endpackage

// ----- rtl/core/lcgr_req_if.sv -----
// ----------------------------------------------------------------------------
// lcgr_req_if
// Request channel: inclusive range bounds, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcgr_req_if import lcgr_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] range_low;
    logic signed [DATA_W-1:0] range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

// ----- rtl/core/lcgr_rsp_if.sv -----
// ----------------------------------------------------------------------------
// lcgr_rsp_if
// Result channel: scaled draw and new generator seed, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcgr_rsp_if import lcgr_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drawn_value;
    logic        [SEED_W-1:0] raw_state;

    modport source (output valid, output drawn_value, output raw_state, input ready);
    modport sink   (input valid, input drawn_value, input raw_state, output ready);
endinterface

// ----- rtl/core/lcg_uniform_range_generator.sv -----
// ----------------------------------------------------------------------------
// lcg_uniform_range_generator
// Minimal standard (multiplier 16807, modulus 2^31-1) generator that scales
// each new seed exactly onto a requested inclusive signed range.
// ----------------------------------------------------------------------------
// Usage:
//   i_req  : request with range_low / range_high (signed, high >= low;
//            an inverted range returns range_low).
//   o_rsp  : result with drawn_value and raw_state (the new seed).
//   i_cfg_we / i_cfg_wdata : loads the generator seed; write only while idle.
// Sequencing:
//   A request is taken only when the sequencer is idle and the output
//   register is empty. After acceptance the sequencer steps through seed
//   multiply, mod fold, span multiply, two division folds and output load
//   on one shared 31x32 multiplier, so a request is not taken before the
//   last one has reached the output register.
// Reset:
//   Synchronous, active low. Seed returns to 1, output register empties.
// Backpressure:
//   A result waits in the output register until o_rsp.ready; no new
//   request is taken while it waits.
// ----------------------------------------------------------------------------
module lcg_uniform_range_generator import lcgr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SEED_W-1:0] i_cfg_wdata,
    lcgr_req_if.sink          i_req,
    lcgr_rsp_if.source        o_rsp
);

    t_ctrl             ctrl;
    logic              req_fire;
    logic [PROD_W-1:0] prod;
    logic              mul_en;
    logic [DATA_W-1:0] mul_b;
    logic              mul_wide;

    logic [SEED_W-1:0] r_seed;
    logic [DATA_W-1:0] r_lo;
    logic [DATA_W-1:0] r_hi;
    logic [SPAN_W-1:0] r_span;
    logic [SPAN_W-1:0] r_y;
    logic [DATA_W-1:0] r_q;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_drawn;

    logic [SPAN_W-1:0] n_span;
    logic [SPAN_W-1:0] diff;
    logic [DATA_W-1:0] fold_sum;
    logic [SEED_W-1:0] n_seed;
    logic [DATA_W-1:0] quot_t;
    logic [DATA_W-1:0] n_q;

    assign i_req.ready = ctrl.idle && !r_out_valid;
    assign req_fire    = i_req.valid && i_req.ready;

    lcgr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (req_fire),
        .o_ctrl  (ctrl)
    );

    // Shared multiplier operand select
    assign mul_en   = ctrl.mul_seed || ctrl.mul_span;
    assign mul_b    = ctrl.mul_span ? r_span[DATA_W-1:0] : LCG_MUL;
    assign mul_wide = ctrl.mul_span && r_span[SPAN_W-1];

    lcgr_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_wide (mul_wide),
        .i_a    (r_seed),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Span = high - low + 1, or 1 for an inverted range
    always_comb begin
        diff = {r_hi[DATA_W-1], r_hi} - {r_lo[DATA_W-1], r_lo};
        if (diff[SPAN_W-1]) begin
            n_span = SPAN_W'(1);
        end else begin
            n_span = diff + SPAN_W'(1);
        end
    end

    // Seed mod fold: 2^31 == 1 mod M, one conditional subtract
    always_comb begin
        fold_sum = prod[PROD_W-1:SEED_W] + {1'b0, prod[SEED_W-1:0]};
        if (fold_sum >= {1'b0, LCG_MOD}) begin
            n_seed = SEED_W'(fold_sum - {1'b0, LCG_MOD});
        end else begin
            n_seed = fold_sum[SEED_W-1:0];
        end
    end

    // Quotient by M: x = a*2^31 + b gives q = a + floor((a + b) / M)
    always_comb begin
        quot_t = {1'b0, r_y[SEED_W-1:0]} + {{(DATA_W-2){1'b0}}, r_y[SPAN_W-1:SEED_W]};
        n_q    = prod[PROD_W-1:SEED_W] + {{(DATA_W-2){1'b0}}, r_y[SPAN_W-1:SEED_W]}
               + {{(DATA_W-1){1'b0}}, (quot_t >= {1'b0, LCG_MOD})};
    end

    // Seed register: config load or fold result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SEED_INIT;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_wdata;
        end else if (ctrl.fold_seed) begin
            r_seed <= n_seed;
        end
    end

    // Datapath payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_lo <= i_req.range_low;
            r_hi <= i_req.range_high;
        end
        if (ctrl.mul_seed) begin
            r_span <= n_span;
        end
        if (ctrl.div_sum) begin
            r_y <= {1'b0, prod[PROD_W-1:SEED_W]} + {2'b00, prod[SEED_W-1:0]};
        end
        if (ctrl.div_quot) begin
            r_q <= n_q;
        end
        if (ctrl.out_load) begin
            r_drawn <= r_lo + r_q;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.drawn_value = r_drawn;
    assign o_rsp.raw_state   = r_seed;

endmodule

// ----- rtl/core/lcgr_mul.sv -----
// ----------------------------------------------------------------------------
// lcgr_mul
// Shared 31 x 32 multiplier with registered product. A wide select loads
// a times 2^32 for the one span that does not fit in 32 bits.
// ----------------------------------------------------------------------------
module lcgr_mul import lcgr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_wide,
    input  logic [SEED_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;

    // Product or shifted operand
    always_comb begin
        if (i_wide) begin
            n_prod = {i_a, {DATA_W{1'b0}}};
        end else begin
            n_prod = {{DATA_W{1'b0}}, i_a} * {{SEED_W{1'b0}}, i_b};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/lcgr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lcgr_ctrl
// Step sequencer: walks one request through seed multiply, modular fold,
// span multiply, two-step constant division and result load.
// ----------------------------------------------------------------------------
module lcgr_ctrl import lcgr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output t_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step strobes
    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                o_ctrl.idle = 1'b1;
                if (i_start) begin
                    n_state = S_MUL_SEED;
                end
            end
            S_MUL_SEED: begin
                o_ctrl.mul_seed = 1'b1;
                n_state         = S_FOLD_SEED;
            end
            S_FOLD_SEED: begin
                o_ctrl.fold_seed = 1'b1;
                n_state          = S_MUL_SPAN;
            end
            S_MUL_SPAN: begin
                o_ctrl.mul_span = 1'b1;
                n_state         = S_DIV_SUM;
            end
            S_DIV_SUM: begin
                o_ctrl.div_sum = 1'b1;
                n_state        = S_DIV_QUOT;
            end
            S_DIV_QUOT: begin
                o_ctrl.div_quot = 1'b1;
                n_state         = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                o_ctrl.out_load = 1'b1;
                n_state         = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the minimal standard uniform range generator.
// A short stimulus table covers reset state, the extreme bounds, reversed
// ranges and the degenerate seeds; several seed phases of random bound pairs
// follow. Both handshake sides idle at random. Every result is compared in
// order with the table or a cycle-free model of seed step and range scaling.
// ----------------------------------------------------------------------------
module tb_top import lcgr_pkg::*;;

    localparam int          CLK_HALF    = 10;
    localparam int          RST_CYCLES  = 7;
    localparam int          PHASES      = 6;
    localparam int          PHASE_ITEMS = 155;
    localparam int          CALM_ITEMS  = 100;
    localparam int          DRAIN_PAUSE = 8;
    localparam int          LONG_HOLD   = 80;
    localparam int          HOLD_AT     = 300;
    localparam int          DIR_ROWS    = 24;
    localparam int          WATCHDOG_NS = 4_000_000;
    localparam logic [63:0] MINSTD_MUL  = 64'd16807;
    localparam logic [63:0] MINSTD_MOD  = 64'd2147483647;

    localparam logic signed [DATA_W-1:0] WORD_MIN  = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX  = 32'sh7FFF_FFFF;
    localparam logic        [SEED_W-1:0] SEED_TOP  = 31'd2147483646;
    localparam logic        [SEED_W-1:0] SEED_ONES = 31'h7FFF_FFFF;

    typedef enum logic {ROW_SEED, ROW_DRAW} t_row_kind;

    // One table row: a seed load, or a request with optional fixed results
    typedef struct {
        t_row_kind                kind;
        logic        [SEED_W-1:0] seed;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        bit                       chk_drawn;
        logic signed [DATA_W-1:0] drawn;
        bit                       chk_raw;
        logic        [SEED_W-1:0] raw;
    } t_stim_row;

    typedef struct {
        logic signed [DATA_W-1:0] drawn;
        logic        [SEED_W-1:0] raw;
    } t_draw;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [SEED_W-1:0] cfg_wdata;

    lcgr_req_if req_if ();
    lcgr_rsp_if rsp_if ();

    // Model state and bookkeeping
    logic [SEED_W-1:0] gen_seed;
    t_draw             pending_draws[$];
    t_stim_row         dir_rows[DIR_ROWS];
    bit                calm = 1'b0;
    int                send_gap_pct;
    int                err_count;
    int                req_count;
    int                reversed_count;
    int                seed_loads;
    int                results_seen;

    lcg_uniform_range_generator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    always #(CLK_HALF) clk = ~clk;

    // Advance the seed by one step and scale it onto [lo, hi]
    function automatic t_draw step_generator(input logic signed [DATA_W-1:0] lo,
                                             input logic signed [DATA_W-1:0] hi);
        logic [63:0] prod;
        logic [32:0] span;
        logic [63:0] offset;
        t_draw       res;
        prod     = {33'd0, gen_seed} * MINSTD_MUL;
        gen_seed = SEED_W'(prod % MINSTD_MOD);
        if (hi < lo) begin
            span = 33'd1;
        end else begin
            span = {hi[DATA_W-1], hi} - {lo[DATA_W-1], lo} + 33'd1;
        end
        offset    = ({33'd0, gen_seed} * {31'd0, span}) / MINSTD_MOD;
        res.drawn = lo + offset[DATA_W-1:0];
        res.raw   = gen_seed;
        return res;
    endfunction

    // Offer one request, wait for it to be taken, then log its expected result
    task automatic offer_request(input t_stim_row row);
        t_draw want;
        if (!calm && $urandom_range(0, 99) < send_gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.range_low  <= row.lo;
        req_if.range_high <= row.hi;
        do @(posedge clk); while (!req_if.ready);
        want = step_generator(row.lo, row.hi);
        if (row.chk_drawn) want.drawn = row.drawn;
        if (row.chk_raw) want.raw = row.raw;
        pending_draws.push_back(want);
        req_count++;
        if (row.hi < row.lo) reversed_count++;
    endtask

    // Stop offering until every result is back, then let the block settle
    task automatic wait_all_drawn();
        req_if.valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Seed loads only go in with the block idle
    task automatic load_seed(input logic [SEED_W-1:0] seed);
        wait_all_drawn();
        cfg_we    <= 1'b1;
        cfg_wdata <= seed;
        @(posedge clk);
        cfg_we   <= 1'b0;
        gen_seed  = seed;
        seed_loads++;
    endtask

    // Stimulus
    initial begin : stimulus
        t_stim_row                row;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        int unsigned              pick;
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_if.valid      <= 1'b0;
        req_if.range_low  <= '0;
        req_if.range_high <= '0;
        gen_seed          = 31'd1;
        send_gap_pct      = 30;
        err_count         = 0;
        req_count         = 0;
        reversed_count    = 0;
        seed_loads        = 0;

        dir_rows = '{
            // reset seed: first step is the multiplier itself
            '{ROW_DRAW, '0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b1, 31'd16807},
            '{ROW_DRAW, '0, WORD_MIN, WORD_MAX, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, WORD_MAX, WORD_MAX, 1'b1, WORD_MAX, 1'b0, '0},
            '{ROW_DRAW, '0, WORD_MIN, WORD_MIN, 1'b1, WORD_MIN, 1'b0, '0},
            // reversed bounds return the low bound
            '{ROW_DRAW, '0, 32'sd5, -32'sd5, 1'b1, 32'sd5, 1'b0, '0},
            '{ROW_DRAW, '0, WORD_MAX, WORD_MIN, 1'b1, WORD_MAX, 1'b0, '0},
            '{ROW_DRAW, '0, -32'sd1, 32'sd0, 1'b0, '0, 1'b0, '0},
            // largest legal seed steps to modulus minus multiplier
            '{ROW_SEED, SEED_TOP, '0, '0, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b1, 31'd2147466840},
            '{ROW_DRAW, '0, 32'sd0, WORD_MAX, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, WORD_MIN, WORD_MAX, 1'b0, '0, 1'b0, '0},
            // zero seed sticks at zero
            '{ROW_SEED, 31'd0, '0, '0, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, 32'sd123, 32'sd456, 1'b1, 32'sd123, 1'b1, 31'd0},
            '{ROW_DRAW, '0, WORD_MIN, WORD_MAX, 1'b1, WORD_MIN, 1'b1, 31'd0},
            '{ROW_DRAW, '0, 32'sd0, -32'sd1, 1'b1, 32'sd0, 1'b1, 31'd0},
            // seed equal to the modulus falls to zero
            '{ROW_SEED, SEED_ONES, '0, '0, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, -32'sd7, 32'sd7, 1'b1, -32'sd7, 1'b1, 31'd0},
            '{ROW_DRAW, '0, 32'sd100, 32'sd100, 1'b1, 32'sd100, 1'b1, 31'd0},
            '{ROW_SEED, 31'd1, '0, '0, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, 32'sd0, 32'sd0, 1'b1, 32'sd0, 1'b1, 31'd16807},
            '{ROW_DRAW, '0, 32'shAAAA_AAAA, 32'sh5555_5555, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, -32'sd1, -32'sd1, 1'b1, -32'sd1, 1'b0, '0},
            '{ROW_SEED, 31'h2AAA_AAAA, '0, '0, 1'b0, '0, 1'b0, '0},
            '{ROW_DRAW, '0, 32'sh5555_5555, WORD_MAX, 1'b0, '0, 1'b0, '0}
        };

        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_SEED) begin
                load_seed(dir_rows[i].seed);
            end else begin
                offer_request(dir_rows[i]);
            end
        end

        // Random phases, each from a fresh seed
        row = '{ROW_DRAW, '0, '0, '0, 1'b0, '0, 1'b0, '0};
        for (int phase = 0; phase < PHASES; phase++) begin
            load_seed(SEED_W'($urandom_range(1, 32'd2147483646)));
            send_gap_pct = (phase % 3) * 30;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (phase == PHASES - 1 && k == PHASE_ITEMS - CALM_ITEMS) calm <= 1'b1;
                // one mid-phase pause until the pipe is empty
                if (phase == 2 && k == 60) wait_all_drawn();
                a    = $urandom;
                b    = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    // reversed bounds
                    row.lo = (a > b) ? a : b;
                    row.hi = (a > b) ? b : a;
                end else if (pick < 30) begin
                    // narrow span
                    row.lo = a;
                    row.hi = a + $urandom_range(0, 15);
                    if (row.hi < row.lo) row.hi = WORD_MAX;
                end else if (pick < 40) begin
                    row.lo = a;
                    row.hi = a;
                end else if (pick < 55) begin
                    // near-full span
                    row.lo = WORD_MIN + $urandom_range(0, 3);
                    row.hi = WORD_MAX - $urandom_range(0, 3);
                end else begin
                    row.lo = (a < b) ? a : b;
                    row.hi = (a < b) ? b : a;
                end
                offer_request(row);
            end
        end

        wait_all_drawn();
        $display("Drove %0d range requests (%0d reversed) over %0d seed loads.",
                 req_count, reversed_count, seed_loads);
        $display("Checked %0d results, %0d field errors.", results_seen, err_count);
        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, in-order compare
    initial begin : result_sink
        t_draw want;
        int    stall_left;
        int    stall_pct;
        int    cyc;
        stall_left   = 0;
        stall_pct    = 30;
        cyc          = 0;
        results_seen = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            cyc++;
            if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready) begin
                results_seen++;
                if (pending_draws.size() == 0) begin
                    $error("unexpected result: drawn_value %0d raw_state %0d",
                           rsp_if.drawn_value, rsp_if.raw_state);
                    err_count++;
                end else begin
                    want = pending_draws.pop_front();
                    if (rsp_if.drawn_value !== want.drawn) begin
                        $error("drawn_value: expected %0d, got %0d",
                               want.drawn, rsp_if.drawn_value);
                        err_count++;
                    end
                    if (rsp_if.raw_state !== want.raw) begin
                        $error("raw_state: expected %0d, got %0d",
                               want.raw, rsp_if.raw_state);
                        err_count++;
                    end
                end
                // back the block up while requests keep coming
                if (results_seen == HOLD_AT) stall_left = LONG_HOLD;
            end
            if (cyc % 64 == 0) stall_pct = $urandom_range(0, 2) * 30;
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
                rsp_if.ready <= 1'b0;
                stall_left = $urandom_range(1, 5) - 1;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lcgr_pkg.sv
rtl/core/lcgr_req_if.sv
rtl/core/lcgr_rsp_if.sv
rtl/core/lcgr_mul.sv
rtl/core/lcgr_ctrl.sv
rtl/core/lcg_uniform_range_generator.sv
test/tb_top.sv
